// ===== design/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

    // Default signed width that a reduced result must fit.
    localparam int DEF_WIDTH = 32;

    // Operation codes carried in the input tuser field.
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_LT     = 4'd4;
    localparam logic [3:0] OP_LE     = 4'd5;
    localparam logic [3:0] OP_GT     = 4'd6;
    localparam logic [3:0] OP_GE     = 4'd7;
    localparam logic [3:0] OP_EQ     = 4'd8;
    localparam logic [3:0] OP_NE     = 4'd9;
    localparam logic [3:0] OP_REDUCE = 4'd10;

    // Sequencer states, one-hot.
    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_GCD   = 14'b00000000000010,
        ST_GSTEP = 14'b00000000000100,
        ST_Q1    = 14'b00000000001000,
        ST_Q2    = 14'b00000000010000,
        ST_Q3    = 14'b00000000100000,
        ST_DIV   = 14'b00000001000000,
        ST_M1    = 14'b00000010000000,
        ST_M2    = 14'b00000100000000,
        ST_M3    = 14'b00001000000000,
        ST_ADD   = 14'b00010000000000,
        ST_CMP   = 14'b00100000000000,
        ST_EMIT  = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    // Which fraction the reduction routine is working on.
    typedef enum logic [1:0] {
        RED_A = 2'd0,
        RED_B = 2'd1,
        RED_L = 2'd2,
        RED_R = 2'd3
    } stage_t;

endpackage

// ===== design/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer, shared divider and multiplier.
//
// Usage: an item on the s_ channel carries an opcode (s_tuser) and two signed
// fractions a and b (s_tdata). One result item leaves on the m_ channel with the
// reduced numerator and denominator (m_tdata) and the flags cmp_true, div_zero
// and overflow (m_tuser). Every operand in use and every fraction result is reduced by its gcd with
// Euclid's algorithm, each remainder and exact quotient coming from one shared
// restoring divider that retires one bit per cycle. One shared 32 by 32
// multiplier forms the cross products, one per cycle. Latency is set by the
// number of Euclid steps. s_tready is high only while the sequencer is idle;
// one item is worked on at a time. A finished result sits in the output
// register until taken, and the next item is accepted meanwhile; a stalled
// receiver holds the sequencer only when a second result is ready. Reset
// (aresetn low, synchronous) empties the output register and returns the
// sequencer to idle.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  logic [127:0] s_tdata,
    // opcode [3:0]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_num [31:0], res_den [62:32], zero [63]
    output logic [63:0]  m_tdata,
    // cmp_true [0], div_zero [1], overflow [2]
    output logic [2:0]   m_tuser
);
    import rau_pkg::*;

    localparam logic [63:0] MAX_POS   = (64'd1 << (WIDTH - 1)) - 64'd1;
    localparam logic [6:0]  DIV_STEPS = 7'd64;

    state_t state_reg, state_next, ret_reg, ret_next;
    stage_t stage_reg, stage_next;

    logic [3:0]  op_reg, op_next;
    logic        a_neg_reg, a_neg_next, b_neg_reg, b_neg_next, r_neg_reg, r_neg_next;
    logic [31:0] am_reg, am_next, ad_reg, ad_next, bm_reg, bm_next, bd_reg, bd_next;
    logic [63:0] n_reg, n_next, d_reg, d_next, x_reg, x_next, y_reg, y_next;
    logic [63:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;

    logic [31:0] p_num_reg, p_num_next;
    logic [30:0] p_den_reg, p_den_next;
    logic        p_cmp_reg, p_cmp_next, p_dz_reg, p_dz_next, p_ovf_reg, p_ovf_next;

    logic        m_valid_reg, m_valid_next;
    logic [62:0] m_data_reg, m_data_next;
    logic [2:0]  m_user_reg, m_user_next;

    // Input split into signs and magnitudes.
    logic [31:0] in_an, in_ad, in_bn, in_bd;
    logic [31:0] an_mag, ad_mag, bn_mag, bd_mag;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    // Shared divider step.
    logic [64:0] div_sh, div_diff;

    // Signed add of two magnitudes and the compare of cross products.
    logic        n2, add_neg, cmp_lt, cmp_eq, cmp_res;
    logic [63:0] add_mag;

    // Saturation of the finished fraction.
    logic        fits;
    logic [63:0] sat_mag;

    assign in_an = s_tdata[31:0];
    assign in_ad = s_tdata[63:32];
    assign in_bn = s_tdata[95:64];
    assign in_bd = s_tdata[127:96];
    assign an_mag = in_an[31] ? (~in_an + 32'd1) : in_an;
    assign ad_mag = in_ad[31] ? (~in_ad + 32'd1) : in_ad;
    assign bn_mag = in_bn[31] ? (~in_bn + 32'd1) : in_bn;
    assign bd_mag = in_bd[31] ? (~in_bd + 32'd1) : in_bd;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};
    assign m_tuser  = m_user_reg;

    // Multiplier operands follow the step of the sequencer and the operation.
    always_comb begin
        mul_a = am_reg;
        mul_b = bd_reg;
        if (op_reg == OP_ADD || op_reg == OP_SUB) begin
            unique case (state_reg)
                ST_M1:   begin mul_a = n_reg[31:0]; mul_b = bd_reg;      end
                ST_M2:   begin mul_a = am_reg;      mul_b = d_reg[31:0]; end
                default: begin mul_a = bm_reg;      mul_b = n_reg[31:0]; end
            endcase
        end else if (op_reg == OP_MUL) begin
            if (state_reg == ST_M1) begin
                mul_a = am_reg; mul_b = bm_reg;
            end else begin
                mul_a = ad_reg; mul_b = bd_reg;
            end
        end else begin
            if (state_reg == ST_M1) begin
                mul_a = am_reg; mul_b = bd_reg;
            end else begin
                mul_a = ad_reg; mul_b = bm_reg;
            end
        end
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // One bit of restoring division.
    assign div_sh   = {rem_reg, quo_reg[63]};
    assign div_diff = div_sh - {1'b0, dvs_reg};

    // Sum of the scaled numerators: x is the lcm, y is t1, n is t2.
    always_comb begin
        n2 = (op_reg == OP_SUB) ? ((n_reg != 64'd0) && !b_neg_reg) : b_neg_reg;
        if (a_neg_reg == n2) begin
            add_mag = y_reg + n_reg;
            add_neg = a_neg_reg;
        end else if (y_reg >= n_reg) begin
            add_mag = y_reg - n_reg;
            add_neg = a_neg_reg;
        end else begin
            add_mag = n_reg - y_reg;
            add_neg = n2;
        end
    end

    // Compare of the cross products held in x and y.
    always_comb begin
        if (a_neg_reg != b_neg_reg) begin
            cmp_lt = a_neg_reg;
        end else begin
            cmp_lt = a_neg_reg ? (x_reg > y_reg) : (x_reg < y_reg);
        end
        cmp_eq = (a_neg_reg == b_neg_reg) && (x_reg == y_reg);
        unique case (op_reg)
            OP_LT:   cmp_res = cmp_lt;
            OP_LE:   cmp_res = cmp_lt || cmp_eq;
            OP_GT:   cmp_res = !(cmp_lt || cmp_eq);
            OP_GE:   cmp_res = !cmp_lt;
            OP_EQ:   cmp_res = cmp_eq;
            default: cmp_res = !cmp_eq;
        endcase
    end

    // Range check and saturation of the reduced result in n and d.
    always_comb begin
        fits = (r_neg_reg ? (n_reg <= MAX_POS + 64'd1) : (n_reg <= MAX_POS)) &&
               (d_reg <= MAX_POS);
        if (fits) begin
            sat_mag = n_reg;
        end else begin
            sat_mag = r_neg_reg ? (MAX_POS + 64'd1) : MAX_POS;
        end
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        stage_next   = stage_reg;
        op_next      = op_reg;
        a_neg_next   = a_neg_reg;
        b_neg_next   = b_neg_reg;
        r_neg_next   = r_neg_reg;
        am_next      = am_reg;
        ad_next      = ad_reg;
        bm_next      = bm_reg;
        bd_next      = bd_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        p_num_next   = p_num_reg;
        p_den_next   = p_den_reg;
        p_cmp_next   = p_cmp_reg;
        p_dz_next    = p_dz_reg;
        p_ovf_next   = p_ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    a_neg_next = in_an[31] ^ in_ad[31];
                    b_neg_next = in_bn[31] ^ in_bd[31];
                    am_next    = an_mag;
                    ad_next    = ad_mag;
                    bm_next    = bn_mag;
                    bd_next    = bd_mag;
                    p_num_next = 32'd0;
                    p_den_next = 31'd0;
                    p_cmp_next = 1'b0;
                    p_dz_next  = 1'b0;
                    p_ovf_next = 1'b0;
                    if (s_tuser > OP_REDUCE) begin
                        state_next = ST_DONE;
                    end else if (ad_mag == 32'd0 ||
                                 (s_tuser != OP_REDUCE && bd_mag == 32'd0)) begin
                        p_dz_next  = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        n_next     = 64'(an_mag);
                        d_next     = 64'(ad_mag);
                        x_next     = 64'(an_mag);
                        y_next     = 64'(ad_mag);
                        stage_next = RED_A;
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                // Euclid loop: x holds the gcd once y reaches zero.
                if (y_reg == 64'd0) begin
                    state_next = ST_Q1;
                end else begin
                    quo_next   = x_reg;
                    rem_next   = 64'd0;
                    dvs_next   = y_reg;
                    cnt_next   = DIV_STEPS;
                    ret_next   = ST_GSTEP;
                    state_next = ST_DIV;
                end
            end
            ST_GSTEP: begin
                x_next     = y_reg;
                y_next     = rem_reg;
                state_next = ST_GCD;
            end
            ST_Q1: begin
                quo_next   = n_reg;
                rem_next   = 64'd0;
                dvs_next   = x_reg;
                cnt_next   = DIV_STEPS;
                ret_next   = ST_Q2;
                state_next = ST_DIV;
            end
            ST_Q2: begin
                n_next     = quo_reg;
                quo_next   = d_reg;
                rem_next   = 64'd0;
                dvs_next   = x_reg;
                cnt_next   = DIV_STEPS;
                ret_next   = ST_Q3;
                state_next = ST_DIV;
            end
            ST_Q3: begin
                // Reduced fraction is in n and d; continue by stage.
                d_next = quo_reg;
                unique case (stage_reg)
                    RED_A: begin
                        am_next    = n_reg[31:0];
                        ad_next    = quo_reg[31:0];
                        a_neg_next = a_neg_reg && (n_reg != 64'd0);
                        if (op_reg == OP_REDUCE) begin
                            r_neg_next = a_neg_reg && (n_reg != 64'd0);
                            state_next = ST_EMIT;
                        end else begin
                            n_next     = 64'(bm_reg);
                            d_next     = 64'(bd_reg);
                            x_next     = 64'(bm_reg);
                            y_next     = 64'(bd_reg);
                            stage_next = RED_B;
                            state_next = ST_GCD;
                        end
                    end
                    RED_B: begin
                        bm_next    = n_reg[31:0];
                        bd_next    = quo_reg[31:0];
                        b_neg_next = b_neg_reg && (n_reg != 64'd0);
                        r_neg_next = a_neg_reg ^ (b_neg_reg && (n_reg != 64'd0));
                        if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                            n_next     = 64'(ad_reg);
                            d_next     = 64'(quo_reg[31:0]);
                            x_next     = 64'(ad_reg);
                            y_next     = 64'(quo_reg[31:0]);
                            stage_next = RED_L;
                            state_next = ST_GCD;
                        end else if (op_reg == OP_DIV && n_reg == 64'd0) begin
                            p_dz_next  = 1'b1;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_M1;
                        end
                    end
                    RED_L: begin
                        state_next = ST_M1;
                    end
                    default: begin
                        r_neg_next = r_neg_reg && (n_reg != 64'd0);
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_DIV: begin
                rem_next = div_diff[64] ? div_sh[63:0] : div_diff[63:0];
                quo_next = {quo_reg[62:0], ~div_diff[64]};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    state_next = ret_reg;
                end
            end
            ST_M1: begin
                if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                    x_next = prod;
                end else if (op_reg == OP_MUL || op_reg == OP_DIV) begin
                    n_next = prod;
                end else begin
                    x_next = prod;
                end
                state_next = ST_M2;
            end
            ST_M2: begin
                if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                    y_next     = prod;
                    state_next = ST_M3;
                end else if (op_reg == OP_MUL || op_reg == OP_DIV) begin
                    d_next     = prod;
                    x_next     = n_reg;
                    y_next     = prod;
                    stage_next = RED_R;
                    state_next = ST_GCD;
                end else begin
                    y_next     = prod;
                    state_next = ST_CMP;
                end
            end
            ST_M3: begin
                n_next     = prod;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                n_next     = add_mag;
                d_next     = x_reg;
                x_next     = add_mag;
                y_next     = x_reg;
                r_neg_next = add_neg;
                stage_next = RED_R;
                state_next = ST_GCD;
            end
            ST_CMP: begin
                p_cmp_next = cmp_res;
                state_next = ST_DONE;
            end
            ST_EMIT: begin
                p_num_next = r_neg_reg ? (~sat_mag[31:0] + 32'd1) : sat_mag[31:0];
                p_den_next = fits ? d_reg[30:0] : 31'd1;
                p_ovf_next = !fits;
                state_next = ST_DONE;
            end
            default: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {p_den_reg, p_num_reg};
                    m_user_next  = {p_ovf_reg, p_dz_reg, p_cmp_reg};
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        ret_reg    <= ret_next;
        stage_reg  <= stage_next;
        op_reg     <= op_next;
        a_neg_reg  <= a_neg_next;
        b_neg_reg  <= b_neg_next;
        r_neg_reg  <= r_neg_next;
        am_reg     <= am_next;
        ad_reg     <= ad_next;
        bm_reg     <= bm_next;
        bd_reg     <= bd_next;
        n_reg      <= n_next;
        d_reg      <= d_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        cnt_reg    <= cnt_next;
        p_num_reg  <= p_num_next;
        p_den_reg  <= p_den_next;
        p_cmp_reg  <= p_cmp_next;
        p_dz_reg   <= p_dz_next;
        p_ovf_reg  <= p_ovf_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the rational arithmetic unit: random and directed fractions checked against a predictor.
`timescale 1ns / 1ps

// Holds the expected results of accepted fractions and checks each result item.
class rau_scoreboard;
    int unsigned width;
    logic [31:0] exp_num[$];
    logic [30:0] exp_den[$];
    logic [2:0]  exp_flags[$];
    int unsigned n_errors;
    int unsigned n_checked;

    function new(int unsigned w);
        width = w;
        n_errors = 0;
        n_checked = 0;
    endfunction

    static function longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    static function void split(logic [31:0] v, output bit neg, output longint unsigned mag);
        neg = v[31];
        mag = neg ? longint'(32'(-v)) : longint'(v);
        mag = mag & 64'hFFFF_FFFF;
    endfunction

    // Reduce a sign-magnitude fraction; the denominator must be nonzero.
    static function void reduce(bit nneg, longint unsigned nmag, bit dneg,
                                longint unsigned dmag, output bit rneg,
                                output longint unsigned rmag,
                                output longint unsigned rden);
        longint unsigned g;
        g = gcd64(nmag, dmag);
        rmag = nmag / g;
        rden = dmag / g;
        rneg = (rmag != 0) && (nneg != dneg);
    endfunction

    // Saturate into the result width and queue the expectation.
    function void push_frac(bit neg, longint unsigned mag, longint unsigned den);
        longint unsigned maxpos;
        bit fits;
        maxpos = (64'd1 << (width - 1)) - 1;
        fits = (neg ? (mag <= maxpos + 1) : (mag <= maxpos)) && (den <= maxpos);
        if (!fits) begin
            mag = neg ? maxpos + 1 : maxpos;
            den = 1;
        end
        exp_num.push_back(neg ? 32'(-mag) : 32'(mag));
        exp_den.push_back(31'(den));
        exp_flags.push_back({!fits, 2'b00});
    endfunction

    // Work out the result of one accepted item.
    function void note_item(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
        bit ann, adn, bnn, bdn, an_neg, bn_neg, rn, n2, lt, eq, res;
        longint unsigned anm, adm, bnm, bdm, am, aden, bm, bden, rm, rden;
        longint unsigned g, l, t1, t2, c1, c2;
        if (op > rau_pkg::OP_REDUCE) begin
            exp_num.push_back('0);
            exp_den.push_back('0);
            exp_flags.push_back('0);
            return;
        end
        split(an, ann, anm);
        split(ad, adn, adm);
        split(bn, bnn, bnm);
        split(bd, bdn, bdm);
        if (adm == 0 || (op != rau_pkg::OP_REDUCE && bdm == 0)) begin
            exp_num.push_back('0);
            exp_den.push_back('0);
            exp_flags.push_back(3'b010);
            return;
        end
        reduce(ann, anm, adn, adm, an_neg, am, aden);
        if (op == rau_pkg::OP_REDUCE) begin
            push_frac(an_neg, am, aden);
            return;
        end
        reduce(bnn, bnm, bdn, bdm, bn_neg, bm, bden);
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                g = gcd64(aden, bden);
                l = (aden / g) * bden;
                t1 = am * (l / aden);
                t2 = bm * (l / bden);
                n2 = (op == rau_pkg::OP_SUB) ? (t2 != 0 && !bn_neg) : bn_neg;
                if (an_neg == n2) begin
                    rm = t1 + t2;
                    rn = an_neg;
                end else if (t1 >= t2) begin
                    rm = t1 - t2;
                    rn = an_neg;
                end else begin
                    rm = t2 - t1;
                    rn = n2;
                end
                if (rm == 0) rn = 0;
                reduce(rn, rm, 0, l, rn, rm, rden);
                push_frac(rn, rm, rden);
            end
            rau_pkg::OP_MUL: begin
                reduce(an_neg != bn_neg, am * bm, 0, aden * bden, rn, rm, rden);
                push_frac(rn, rm, rden);
            end
            rau_pkg::OP_DIV: begin
                if (bm == 0) begin
                    exp_num.push_back('0);
                    exp_den.push_back('0);
                    exp_flags.push_back(3'b010);
                end else begin
                    reduce(an_neg != bn_neg, am * bden, 0, aden * bm, rn, rm, rden);
                    push_frac(rn, rm, rden);
                end
            end
            default: begin
                c1 = am * bden;
                c2 = bm * aden;
                if (an_neg != bn_neg) lt = an_neg;
                else lt = an_neg ? (c1 > c2) : (c1 < c2);
                eq = (an_neg == bn_neg) && (c1 == c2);
                case (op)
                    rau_pkg::OP_LT: res = lt;
                    rau_pkg::OP_LE: res = lt || eq;
                    rau_pkg::OP_GT: res = !(lt || eq);
                    rau_pkg::OP_GE: res = !lt;
                    rau_pkg::OP_EQ: res = eq;
                    default:        res = !eq;
                endcase
                exp_num.push_back('0);
                exp_den.push_back('0);
                exp_flags.push_back({2'b00, res});
            end
        endcase
    endfunction

    // Compare one result item with the oldest expectation.
    function void check_result(logic [63:0] data, logic [2:0] flags);
        logic [31:0] en;
        logic [30:0] ed;
        logic [2:0] ef;
        if (exp_num.size() == 0) begin
            $error("unexpected result item: tdata %h tuser %b", data, flags);
            n_errors++;
            return;
        end
        en = exp_num.pop_front();
        ed = exp_den.pop_front();
        ef = exp_flags.pop_front();
        n_checked++;
        if (data[31:0] !== en) begin
            $error("res_num: expected %0d, got %0d", $signed(en), $signed(data[31:0]));
            n_errors++;
        end
        if (data[62:32] !== ed) begin
            $error("res_den: expected %0d, got %0d", ed, data[62:32]);
            n_errors++;
        end
        if (flags[0] !== ef[0]) begin
            $error("cmp_true: expected %b, got %b", ef[0], flags[0]);
            n_errors++;
        end
        if (flags[1] !== ef[1]) begin
            $error("div_zero: expected %b, got %b", ef[1], flags[1]);
            n_errors++;
        end
        if (flags[2] !== ef[2]) begin
            $error("overflow: expected %b, got %b", ef[2], flags[2]);
            n_errors++;
        end
    endfunction
endclass

module tb_top;
    import rau_pkg::*;

    localparam int W = DEF_WIDTH;
    localparam longint CYCLE_LIMIT = 64'd100_000_000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    rau_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_recv;
    longint cycles;
    int n_sent;

    rational_arithmetic_unit #(.WIDTH(W)) dut (.*);

    always #5 aclk = ~aclk;

    // Cycle counter with a timeout.
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: random stalls, check each accepted result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item and wait until it is accepted; tvalid stays up until the
    // next item or an idle cycle takes its place.
    task automatic send_item(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {bd, bn, ad, an};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, an, ad, bn, bd);
        n_sent++;
    endtask

    // Random value, biased toward small magnitudes and extremes.
    function automatic logic [31:0] rand_val();
        case ($urandom_range(9))
            0, 1, 2, 3: return 32'($signed($urandom_range(40)) - 20);
            4, 5:       return 32'($signed($urandom_range(2000)) - 1000);
            6:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            7:          return 32'($urandom_range(100)) * 32'($urandom_range(100000));
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_random(int count);
        logic [3:0] op;
        repeat (count) begin
            op = ($urandom_range(30) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
            send_item(op, rand_val(), rand_val(), rand_val(), rand_val());
        end
    endtask

    // Stop offering items and wait until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 0;
        while (sb.exp_num.size() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new(W);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 0;
        n_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: every operation, extremes, zero denominators, overflow.
        send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_item(OP_MUL, -32'sd4, 32'd6, 32'd3, -32'sd8);
        send_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
        send_item(OP_DIV, 32'd3, 32'd4, -32'sd9, 32'd2);
        send_item(OP_LT, 32'd1, 32'd3, 32'd1, 32'd2);
        send_item(OP_LE, 32'd2, 32'd4, 32'd1, 32'd2);
        send_item(OP_GT, -32'sd1, 32'd3, 32'd1, -32'sd2);
        send_item(OP_GE, 32'd0, 32'd5, 32'd0, -32'sd7);
        send_item(OP_EQ, 32'd6, -32'sd4, -32'sd3, 32'd2);
        send_item(OP_NE, 32'd6, -32'sd4, -32'sd3, 32'd2);
        send_item(OP_REDUCE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(OP_REDUCE, 32'd0, 32'h8000_0000, 32'd1, 32'd1);
        send_item(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
        send_item(OP_MUL, 32'd1, 32'd1, 32'd5, 32'd0);
        send_item(OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_item(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_item(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        send_item(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_item(OP_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
        send_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LT, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(4'd11, 32'd1, 32'd1, 32'd1, 32'd1);
        send_item(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases with different idling patterns.
        send_random(180);
        send_idle_pct = 84;
        send_random(120);
        send_idle_pct = 0;
        recv_stall_pct = 84;
        send_random(120);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        send_random(120);

        // Long receiver hold-off while the sender keeps offering items.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_recv = 1;
                repeat (5000) @(posedge aclk);
                hold_recv = 0;
            end
            send_random(6);
        join
        send_random(140);

        drain();
        repeat (100) @(posedge aclk);
        $display("Sent %0d items over all opcodes with sender and receiver idling;", n_sent);
        $display("%0d results checked, %0d mismatches.", sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.exp_num.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
